// ===== rtl/pmq_pkg.sv =====
// ----------------------------------------------------------------------------
// pmq_pkg
// Shared types and constants of the two-class priority message queue.
// ----------------------------------------------------------------------------
package pmq_pkg;

   // Port field widths fixed by the interface
   localparam int MSG_PORT_W  = 32;
   localparam int COUNT_W     = 7;
   localparam int LEN_REG_W   = 7;
   localparam int CSR_INDEX_W = 2;

   // Reset value of both ring length registers
   localparam logic [LEN_REG_W-1:0] LEN_RESET = 7'd64;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_NORMAL_LENGTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRIORITY_LENGTH = 2'd1;

   // Request kinds as coded on req_tuser
   typedef enum logic [1:0] {
      REQ_PUSH_NORMAL   = 2'd0,
      REQ_PUSH_PRIORITY = 2'd1,
      REQ_RECEIVE       = 2'd2,
      REQ_PEEK          = 2'd3
   } req_kind_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_FAILED = 2'd1,
      STATUS_HELD   = 2'd2
   } status_type;

   // Classified command passed from the front end to the ring engine
   typedef struct packed {
      req_kind_type kind;
      logic         wait_flag;
   } cmd_type;

endpackage

// ===== rtl/pmq_ram.sv =====
// ----------------------------------------------------------------------------
// pmq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pmq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pmq_front.sv =====
// ----------------------------------------------------------------------------
// pmq_front
// Request intake: decodes each transaction into a command and holds it in a
// two-entry queue until the ring engine takes it.
// ----------------------------------------------------------------------------
module pmq_front #(
   parameter int MSG_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [1:0]                     req_type_code,
   input  logic [pmq_pkg::MSG_PORT_W-1:0] req_word,
   input  logic                           req_wait,
   output logic                           cmd_valid,
   output pmq_pkg::cmd_type               cmd,
   output logic [MSG_WIDTH-1:0]           cmd_word,
   input  logic                           cmd_pop
);

   localparam int WIDE_W = (MSG_WIDTH > pmq_pkg::MSG_PORT_W) ? MSG_WIDTH : pmq_pkg::MSG_PORT_W;

   pmq_pkg::cmd_type       q_cmd_ff  [2];
   logic [MSG_WIDTH-1:0]   q_word_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   logic                   push;
   logic                   pop;
   logic [WIDE_W-1:0]      word_wide;
   pmq_pkg::cmd_type       new_cmd;

   // Classify the incoming transaction
   assign word_wide         = WIDE_W'(req_word);
   assign new_cmd.kind      = pmq_pkg::req_kind_type'(req_type_code);
   assign new_cmd.wait_flag = req_wait;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != 2'd0);
   assign pop        = cmd_pop && cmd_valid;
   assign cmd        = q_cmd_ff[rd_ptr_ff];
   assign cmd_word   = q_word_ff[rd_ptr_ff];

   // Advance queue pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the command payload
   always_ff @(posedge clock) begin
      if (push) begin
         q_cmd_ff[wr_ptr_ff]  <= new_cmd;
         q_word_ff[wr_ptr_ff] <= word_wide[MSG_WIDTH-1:0];
      end
   end

endmodule

// ===== rtl/pmq_engine.sv =====
// ----------------------------------------------------------------------------
// pmq_engine
// Ring engine: holds the ring length registers, pointers and fills, carries
// out one command at a time against the two ring memories and registers the
// result until it is taken.
// ----------------------------------------------------------------------------
module pmq_engine #(
   parameter int RING_DEPTH = 64,
   parameter int MSG_WIDTH  = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [pmq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pmq_pkg::LEN_REG_W-1:0]   csr_data,
   input  logic                            cmd_valid,
   input  pmq_pkg::cmd_type                cmd,
   input  logic [MSG_WIDTH-1:0]            cmd_word,
   output logic                            cmd_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output pmq_pkg::status_type             rsp_status,
   output logic [pmq_pkg::MSG_PORT_W-1:0]  rsp_msg,
   output logic                            rsp_from_priority,
   output logic [pmq_pkg::COUNT_W-1:0]     rsp_normal_count,
   output logic [pmq_pkg::COUNT_W-1:0]     rsp_priority_count
);

   localparam int PTR_W  = $clog2(RING_DEPTH);
   localparam int FILL_W = $clog2(RING_DEPTH + 1);
   localparam int CMP_W  = (FILL_W > pmq_pkg::LEN_REG_W) ? FILL_W : pmq_pkg::LEN_REG_W;
   localparam int WIDE_W = (MSG_WIDTH > pmq_pkg::MSG_PORT_W) ? MSG_WIDTH : pmq_pkg::MSG_PORT_W;
   localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(RING_DEPTH);
   localparam logic [CMP_W-1:0] ONE_CMP   = CMP_W'(1);

   typedef enum logic [1:0] {
      ST_DECIDE,
      ST_READ,
      ST_HOLD
   } state_type;

   state_type                         state_ff, state_in;
   logic [pmq_pkg::LEN_REG_W-1:0]     nlen_reg_ff, nlen_reg_in;
   logic [pmq_pkg::LEN_REG_W-1:0]     plen_reg_ff, plen_reg_in;
   logic [PTR_W-1:0]                  nrd_ptr_ff, nrd_ptr_in;
   logic [PTR_W-1:0]                  nwr_ptr_ff, nwr_ptr_in;
   logic [PTR_W-1:0]                  prd_ptr_ff, prd_ptr_in;
   logic [PTR_W-1:0]                  pwr_ptr_ff, pwr_ptr_in;
   logic [FILL_W-1:0]                 nfill_ff, nfill_in;
   logic [FILL_W-1:0]                 pfill_ff, pfill_in;
   logic                              sel_pri_ff, sel_pri_in;
   pmq_pkg::status_type               status_ff, status_in;
   logic [pmq_pkg::MSG_PORT_W-1:0]    msg_ff, msg_in;
   logic                              from_pri_ff, from_pri_in;
   logic [pmq_pkg::COUNT_W-1:0]       ncount_ff, ncount_in;
   logic [pmq_pkg::COUNT_W-1:0]       pcount_ff, pcount_in;

   logic [CMP_W-1:0]                  nlen;
   logic [CMP_W-1:0]                  plen;
   logic [CMP_W-1:0]                  nfill_cmp;
   logic [CMP_W-1:0]                  pfill_cmp;
   logic [CMP_W-1:0]                  nfill_next_cmp;
   logic [CMP_W-1:0]                  pfill_next_cmp;
   logic [WIDE_W-1:0]                 rd_wide;
   pmq_pkg::status_type               blocked;

   logic                              nram_we, pram_we;
   logic                              nram_re, pram_re;
   logic [MSG_WIDTH-1:0]              nram_rd_data, pram_rd_data;

   // Clamp a length register to 1..RING_DEPTH
   function automatic logic [CMP_W-1:0] eff_len(input logic [pmq_pkg::LEN_REG_W-1:0] reg_val);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(reg_val);
      if (reg_val == '0) begin
         return ONE_CMP;
      end else if (wide > DEPTH_CMP) begin
         return DEPTH_CMP;
      end
      return wide;
   endfunction

   // Step a ring pointer, wrapping at the effective length
   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr,
                                                input logic [CMP_W-1:0] len);
      logic [CMP_W-1:0] nxt;
      nxt = CMP_W'(ptr) + ONE_CMP;
      if (nxt >= len) begin
         return '0;
      end
      return nxt[PTR_W-1:0];
   endfunction

   assign nlen      = eff_len(nlen_reg_ff);
   assign plen      = eff_len(plen_reg_ff);
   assign nfill_cmp = CMP_W'(nfill_ff);
   assign pfill_cmp = CMP_W'(pfill_ff);
   assign blocked   = cmd.wait_flag ? pmq_pkg::STATUS_HELD : pmq_pkg::STATUS_FAILED;
   assign rd_wide   = sel_pri_ff ? WIDE_W'(pram_rd_data) : WIDE_W'(nram_rd_data);
   assign nfill_next_cmp = CMP_W'(nfill_in);
   assign pfill_next_cmp = CMP_W'(pfill_in);

   // Next-state and result logic
   always_comb begin
      state_in    = state_ff;
      nlen_reg_in = nlen_reg_ff;
      plen_reg_in = plen_reg_ff;
      nrd_ptr_in  = nrd_ptr_ff;
      nwr_ptr_in  = nwr_ptr_ff;
      prd_ptr_in  = prd_ptr_ff;
      pwr_ptr_in  = pwr_ptr_ff;
      nfill_in    = nfill_ff;
      pfill_in    = pfill_ff;
      sel_pri_in  = sel_pri_ff;
      status_in   = status_ff;
      msg_in      = msg_ff;
      from_pri_in = from_pri_ff;
      cmd_pop     = 1'b0;
      nram_we     = 1'b0;
      pram_we     = 1'b0;
      nram_re     = 1'b0;
      pram_re     = 1'b0;

      // Take register writes
      if (csr_write) begin
         if (csr_index == pmq_pkg::CSR_NORMAL_LENGTH) begin
            nlen_reg_in = csr_data;
         end else if (csr_index == pmq_pkg::CSR_PRIORITY_LENGTH) begin
            plen_reg_in = csr_data;
         end
      end

      unique case (state_ff)
         ST_DECIDE: begin
            if (cmd_valid) begin
               cmd_pop     = 1'b1;
               status_in   = pmq_pkg::STATUS_DONE;
               msg_in      = '0;
               from_pri_in = 1'b0;
               state_in    = ST_HOLD;
               unique case (cmd.kind)
                  pmq_pkg::REQ_PUSH_NORMAL: begin
                     if (nfill_cmp < nlen) begin
                        nram_we    = 1'b1;
                        nwr_ptr_in = advance(nwr_ptr_ff, nlen);
                        nfill_in   = nfill_ff + FILL_W'(1);
                     end else begin
                        status_in = blocked;
                     end
                  end
                  pmq_pkg::REQ_PUSH_PRIORITY: begin
                     if (pfill_cmp < plen) begin
                        pram_we    = 1'b1;
                        pwr_ptr_in = advance(pwr_ptr_ff, plen);
                        pfill_in   = pfill_ff + FILL_W'(1);
                     end else begin
                        status_in = blocked;
                     end
                  end
                  pmq_pkg::REQ_RECEIVE: begin
                     if (pfill_ff != '0) begin
                        pram_re     = 1'b1;
                        prd_ptr_in  = advance(prd_ptr_ff, plen);
                        pfill_in    = pfill_ff - FILL_W'(1);
                        from_pri_in = 1'b1;
                        sel_pri_in  = 1'b1;
                        state_in    = ST_READ;
                     end else if (nfill_ff != '0) begin
                        nram_re    = 1'b1;
                        nrd_ptr_in = advance(nrd_ptr_ff, nlen);
                        nfill_in   = nfill_ff - FILL_W'(1);
                        sel_pri_in = 1'b0;
                        state_in   = ST_READ;
                     end else begin
                        status_in = blocked;
                     end
                  end
                  pmq_pkg::REQ_PEEK: begin
                     if (nfill_ff != '0) begin
                        nram_re    = 1'b1;
                        sel_pri_in = 1'b0;
                        state_in   = ST_READ;
                     end else begin
                        status_in = pmq_pkg::STATUS_FAILED;
                     end
                  end
                  default: begin
                     status_in = pmq_pkg::STATUS_FAILED;
                  end
               endcase
            end
         end
         ST_READ: begin
            msg_in   = rd_wide[pmq_pkg::MSG_PORT_W-1:0];
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_ready) begin
               state_in = ST_DECIDE;
            end
         end
         default: begin
            state_in = ST_DECIDE;
         end
      endcase

      ncount_in = nfill_next_cmp[pmq_pkg::COUNT_W-1:0];
      pcount_in = pfill_next_cmp[pmq_pkg::COUNT_W-1:0];
   end

   // Hold state, ring bookkeeping and the registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_DECIDE;
         nlen_reg_ff <= pmq_pkg::LEN_RESET;
         plen_reg_ff <= pmq_pkg::LEN_RESET;
         nrd_ptr_ff  <= '0;
         nwr_ptr_ff  <= '0;
         prd_ptr_ff  <= '0;
         pwr_ptr_ff  <= '0;
         nfill_ff    <= '0;
         pfill_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         nlen_reg_ff <= nlen_reg_in;
         plen_reg_ff <= plen_reg_in;
         nrd_ptr_ff  <= nrd_ptr_in;
         nwr_ptr_ff  <= nwr_ptr_in;
         prd_ptr_ff  <= prd_ptr_in;
         pwr_ptr_ff  <= pwr_ptr_in;
         nfill_ff    <= nfill_in;
         pfill_ff    <= pfill_in;
      end
      sel_pri_ff  <= sel_pri_in;
      status_ff   <= status_in;
      msg_ff      <= msg_in;
      from_pri_ff <= from_pri_in;
      ncount_ff   <= ncount_in;
      pcount_ff   <= pcount_in;
   end

   assign rsp_valid          = (state_ff == ST_HOLD);
   assign rsp_status         = status_ff;
   assign rsp_msg            = msg_ff;
   assign rsp_from_priority  = from_pri_ff;
   assign rsp_normal_count   = ncount_ff;
   assign rsp_priority_count = pcount_ff;

   // Ring storage
   pmq_ram #(
      .WIDTH (MSG_WIDTH),
      .DEPTH (RING_DEPTH)
   ) u_normal_ring (
      .clock   (clock),
      .wr_en   (nram_we),
      .wr_addr (nwr_ptr_ff),
      .wr_data (cmd_word),
      .rd_en   (nram_re),
      .rd_addr (nrd_ptr_ff),
      .rd_data (nram_rd_data)
   );

   pmq_ram #(
      .WIDTH (MSG_WIDTH),
      .DEPTH (RING_DEPTH)
   ) u_priority_ring (
      .clock   (clock),
      .wr_en   (pram_we),
      .wr_addr (pwr_ptr_ff),
      .wr_data (cmd_word),
      .rd_en   (pram_re),
      .rd_addr (prd_ptr_ff),
      .rd_data (pram_rd_data)
   );

endmodule

// ===== rtl/two_class_priority_message_fifo.sv =====
// ----------------------------------------------------------------------------
// two_class_priority_message_fifo
// Strict-priority message queue with a normal ring and a priority ring.
//
//   Channel  Direction  Handshake              Contents
//   req      in         req_tvalid/req_tready  push normal/priority, receive, peek
//   rsp      out        rsp_tvalid/rsp_tready  status, message, both fill counts
//   csr      in         csr_valid/csr_ready    ring length registers 0 and 1
//
// Requests enter a two-entry command queue and are served one at a time by
// the ring engine: a push or a blocked request goes from the decide state to
// the hold state, a receive or peek passes a read state for the registered
// ring read. Reset is synchronous, clears pointers and fills and sets both
// lengths to 64; no clearing pass is needed. While a result waits on rsp the
// command queue takes requests until full; csr writes are always accepted.
// ----------------------------------------------------------------------------
module two_class_priority_message_fifo #(
   parameter int RING_DEPTH = 64,
   parameter int MSG_WIDTH  = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] msg_word, [32] wait_if_blocked, [39:33] zero
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] msg_out, [38:32] normal_count,
                                    // [45:39] priority_count, [47:46] zero
   output logic [2:0]  rsp_tuser,   // [1:0] status, [2] from_priority
   // Configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data
);

   pmq_pkg::cmd_type                 cmd;
   logic                             cmd_valid;
   logic                             cmd_pop;
   logic [MSG_WIDTH-1:0]             cmd_word;
   pmq_pkg::status_type              rsp_status;
   logic [pmq_pkg::MSG_PORT_W-1:0]   rsp_msg;
   logic                             rsp_from_priority;
   logic [pmq_pkg::COUNT_W-1:0]      rsp_normal_count;
   logic [pmq_pkg::COUNT_W-1:0]      rsp_priority_count;

   assign csr_ready = 1'b1;

   // Accept and classify requests
   pmq_front #(
      .MSG_WIDTH (MSG_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_type_code (req_tuser),
      .req_word      (req_tdata[31:0]),
      .req_wait      (req_tdata[32]),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_word      (cmd_word),
      .cmd_pop       (cmd_pop)
   );

   // Carry out commands against the rings
   pmq_engine #(
      .RING_DEPTH (RING_DEPTH),
      .MSG_WIDTH  (MSG_WIDTH)
   ) u_engine (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_word           (cmd_word),
      .cmd_pop            (cmd_pop),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_status         (rsp_status),
      .rsp_msg            (rsp_msg),
      .rsp_from_priority  (rsp_from_priority),
      .rsp_normal_count   (rsp_normal_count),
      .rsp_priority_count (rsp_priority_count)
   );

   // Pack the result transaction
   assign rsp_tdata = {2'b00, rsp_priority_count, rsp_normal_count, rsp_msg};
   assign rsp_tuser = {rsp_from_priority, rsp_status};

endmodule
